>>> src/ipv4_lpm_trie_arp_forwarder_assert.svh
// Assertion macros for the forwarder. Clock i_clk, reset i_rst_n (active low).
`ifndef IPV4_LPM_TRIE_ARP_FORWARDER_ASSERT_SVH
`define IPV4_LPM_TRIE_ARP_FORWARDER_ASSERT_SVH
`ifndef SYNTH
`define LPMF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lpm forwarder check failed");
`define LPMF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("lpm forwarder forbidden condition");
`else
`define LPMF_ASSERT(lbl, prop)
`define LPMF_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> src/lpmfwd_pkg.sv
`default_nettype none
package lpmfwd_pkg;

    localparam int TrieNodeCountDef = 4096;
    localparam int ArpEntryCountDef = 16;
    localparam int TopBit           = 31;

    localparam logic [2:0] ST_FORWARD      = 3'd0;
    localparam logic [2:0] ST_TTL_EXPIRED  = 3'd1;
    localparam logic [2:0] ST_NO_ROUTE     = 3'd2;
    localparam logic [2:0] ST_ARP_NEEDED   = 3'd3;
    localparam logic [2:0] ST_NODE_WRITTEN = 3'd4;
    localparam logic [2:0] ST_LEARNED      = 3'd5;
    localparam logic [2:0] ST_KNOWN        = 3'd6;
    localparam logic [2:0] ST_ARP_FULL     = 3'd7;

    localparam int InWidth  = 168;
    localparam int OutWidth = 96;

    typedef enum logic [1:0] {
        K_WRITE  = 2'd0,
        K_LEARN  = 2'd1,
        K_LOOKUP = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        wr_ok;
        logic [11:0] node_index;
        logic [11:0] child_zero;
        logic [11:0] child_one;
        logic        has_route;
        logic [3:0]  port;
        logic [31:0] hop_addr;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [7:0]  new_ttl;
        logic        ttl_zero;
    } t_cmd;

    typedef struct packed {
        logic [31:0] hop_addr;
        logic [3:0]  port;
        logic        has_route;
        logic [11:0] child_one;
        logic [11:0] child_zero;
    } t_node;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
    } t_arp;

    typedef struct packed {
        logic [7:0]  ttl;
        logic [47:0] mac;
        logic [31:0] hop_addr;
        logic [3:0]  port;
        logic [2:0]  status;
    } t_result;

endpackage
`default_nettype wire

>>> src/lpmfwd_ram.sv
`default_nettype none
module lpmfwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> src/lpmfwd_front.sv
`default_nettype none
module lpmfwd_front #(
    parameter int TRIE_NODE_COUNT = lpmfwd_pkg::TrieNodeCountDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [lpmfwd_pkg::InWidth-1:0] i_s_axis_tdata,
    input  wire logic                           i_clearing,
    output logic                                o_q_valid,
    output lpmfwd_pkg::t_cmd                    o_q_data,
    input  wire logic                           i_q_pop
);
    import lpmfwd_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic [1:0] cmd;
    logic [7:0] ttl;
    logic       push;

    always_comb begin
        cmd = i_s_axis_tdata[1:0];
        ttl = i_s_axis_tdata[162:155];
        case (cmd)
            K_WRITE: dec.kind = K_WRITE;
            K_LEARN: dec.kind = K_LEARN;
            default: dec.kind = K_LOOKUP;
        endcase
        dec.node_index = i_s_axis_tdata[13:2];
        dec.wr_ok      = 32'(dec.node_index) < 32'(TRIE_NODE_COUNT);
        dec.child_zero = i_s_axis_tdata[25:14];
        dec.child_one  = i_s_axis_tdata[37:26];
        dec.has_route  = i_s_axis_tdata[38];
        dec.port       = i_s_axis_tdata[42:39];
        dec.hop_addr   = i_s_axis_tdata[74:43];
        dec.ip         = i_s_axis_tdata[106:75];
        dec.mac        = i_s_axis_tdata[154:107];
        dec.new_ttl    = (ttl == 8'd0) ? 8'd0 : ttl - 8'd1;
        dec.ttl_zero   = (ttl == 8'd0) || (ttl == 8'd1);
    end

    assign o_s_axis_tready = (r_cnt != 2'd2) && !i_clearing;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_cnt != 2'd0);
    assign o_q_data        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end
endmodule
`default_nettype wire

>>> src/lpmfwd_back.sv
`default_nettype none
`include "ipv4_lpm_trie_arp_forwarder_assert.svh"
module lpmfwd_back #(
    parameter int TRIE_NODE_COUNT = lpmfwd_pkg::TrieNodeCountDef,
    parameter int ARP_ENTRY_COUNT = lpmfwd_pkg::ArpEntryCountDef
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire lpmfwd_pkg::t_cmd                i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_clearing,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [lpmfwd_pkg::OutWidth-1:0] o_m_axis_tdata
);
    import lpmfwd_pkg::*;

    localparam int AW  = $clog2(TRIE_NODE_COUNT);
    localparam int AIW = (ARP_ENTRY_COUNT > 1) ? $clog2(ARP_ENTRY_COUNT) : 1;
    localparam int ACW = $clog2(ARP_ENTRY_COUNT + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_WALK  = 6'b000100,
        S_ARP   = 6'b001000,
        S_AFIN  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr, n_clr;
    t_cmd            r_cmd, n_cmd;
    logic [31:0]     r_ip, n_ip;
    logic [5:0]      r_depth, n_depth;
    logic            r_first, n_first;
    logic            r_found, n_found;
    logic [3:0]      r_port, n_port;
    logic [31:0]     r_nh, n_nh;
    logic [31:0]     r_key, n_key;
    logic            r_match, n_match;
    logic [47:0]     r_mac, n_mac;
    logic [AIW-1:0]  r_idx, n_idx;
    logic [ACW-1:0]  r_count, n_count;
    t_result         r_res, n_res;
    t_result         r_out, n_out;
    logic            r_ovalid, n_ovalid;

    logic            trie_we;
    logic [AW-1:0]   trie_waddr, trie_raddr;
    t_node           trie_wdata, node;
    logic            arp_we;
    logic [AIW-1:0]  arp_waddr, arp_raddr;
    t_arp            arp_wdata, arp_rd;
    logic            arp_go;
    logic [31:0]     arp_key;
    logic [11:0]     nxt;
    logic [31:0]     nxt_ext, idx_ext;

    lpmfwd_ram #(.WIDTH($bits(t_node)), .DEPTH(TRIE_NODE_COUNT), .AW(AW)) u_trie (
        .i_clk   (i_clk),
        .i_we    (trie_we),
        .i_waddr (trie_waddr),
        .i_wdata (trie_wdata),
        .i_raddr (trie_raddr),
        .o_rdata (node)
    );

    lpmfwd_ram #(.WIDTH($bits(t_arp)), .DEPTH(ARP_ENTRY_COUNT), .AW(AIW)) u_arp (
        .i_clk   (i_clk),
        .i_we    (arp_we),
        .i_waddr (arp_waddr),
        .i_wdata (arp_wdata),
        .i_raddr (arp_raddr),
        .o_rdata (arp_rd)
    );

    assign o_clearing      = (r_state == S_CLEAR);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {1'b0, r_out};

    always_comb begin
        n_state = r_state;  n_clr = r_clr;      n_cmd = r_cmd;
        n_ip = r_ip;        n_depth = r_depth;  n_first = r_first;
        n_found = r_found;  n_port = r_port;    n_nh = r_nh;
        n_key = r_key;      n_match = r_match;  n_mac = r_mac;
        n_idx = r_idx;      n_count = r_count;  n_res = r_res;
        n_out = r_out;      n_ovalid = r_ovalid;
        o_q_pop    = 1'b0;
        trie_we    = 1'b0;
        trie_waddr = r_clr;
        trie_wdata = '0;
        trie_raddr = '0;
        arp_we     = 1'b0;
        arp_waddr  = r_count[AIW-1:0];
        arp_wdata  = '{mac: r_cmd.mac, ip: r_cmd.ip};
        arp_raddr  = '0;
        arp_go     = 1'b0;
        arp_key    = r_nh;
        idx_ext    = 32'(i_q_data.node_index);
        nxt        = r_ip[TopBit] ? node.child_one : node.child_zero;
        nxt_ext    = 32'(nxt);

        if (r_ovalid && i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                trie_we = 1'b1;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(TRIE_NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_res   = '0;
                    case (i_q_data.kind)
                        K_WRITE: begin
                            trie_we    = i_q_data.wr_ok;
                            trie_waddr = idx_ext[AW-1:0];
                            trie_wdata = '{hop_addr: i_q_data.hop_addr,
                                           port: i_q_data.port,
                                           has_route: i_q_data.has_route,
                                           child_one: i_q_data.child_one,
                                           child_zero: i_q_data.child_zero};
                            n_res.status = ST_NODE_WRITTEN;
                            n_state = S_DONE;
                        end
                        K_LEARN: begin
                            arp_go  = 1'b1;
                            arp_key = i_q_data.ip;
                        end
                        default: begin
                            if (i_q_data.ttl_zero) begin
                                n_res.status = ST_TTL_EXPIRED;
                                n_res.ttl    = i_q_data.new_ttl;
                                n_state      = S_DONE;
                            end else begin
                                n_ip    = i_q_data.ip;
                                n_depth = '0;
                                n_first = 1'b1;
                                n_found = 1'b0;
                                n_port  = '0;
                                n_nh    = '0;
                                n_state = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                // node holds the entry read last cycle; the root's own route is skipped
                if (!r_first && node.has_route) begin
                    n_found = 1'b1;
                    n_port  = node.port;
                    n_nh    = node.hop_addr;
                end
                n_first = 1'b0;
                if (r_depth == 6'd32 || nxt == 12'd0
                        || !(nxt_ext < 32'(TRIE_NODE_COUNT))) begin
                    if (n_found) begin
                        arp_go  = 1'b1;
                        arp_key = n_nh;
                    end else begin
                        n_res.status = ST_NO_ROUTE;
                        n_res.ttl    = r_cmd.new_ttl;
                        n_state      = S_DONE;
                    end
                end else begin
                    trie_raddr = nxt_ext[AW-1:0];
                    n_ip       = {r_ip[30:0], 1'b0};
                    n_depth    = r_depth + 6'd1;
                end
            end
            S_ARP: begin
                if (arp_rd.ip == r_key) begin
                    n_match = 1'b1;
                    n_mac   = arp_rd.mac;
                    n_state = S_AFIN;
                end else if (ACW'(r_idx) + ACW'(1) == r_count) begin
                    n_state = S_AFIN;
                end else begin
                    n_idx     = r_idx + AIW'(1);
                    arp_raddr = n_idx;
                end
            end
            S_AFIN: begin
                n_state = S_DONE;
                if (r_cmd.kind == K_LEARN) begin
                    if (r_match) begin
                        n_res.status = ST_KNOWN;
                    end else if (r_count == ACW'(ARP_ENTRY_COUNT)) begin
                        n_res.status = ST_ARP_FULL;
                    end else begin
                        arp_we       = 1'b1;
                        n_count      = r_count + ACW'(1);
                        n_res.status = ST_LEARNED;
                    end
                end else begin
                    n_res.status   = r_match ? ST_FORWARD : ST_ARP_NEEDED;
                    n_res.port     = r_port;
                    n_res.hop_addr = r_nh;
                    n_res.mac      = r_match ? r_mac : 48'd0;
                    n_res.ttl      = r_cmd.new_ttl;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_out    = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // cache scan shared by learn and lookup
        if (arp_go) begin
            n_key   = arp_key;
            n_match = 1'b0;
            n_idx   = '0;
            n_state = (r_count == '0) ? S_AFIN : S_ARP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_cmd   <= n_cmd;
        r_ip    <= n_ip;
        r_depth <= n_depth;
        r_first <= n_first;
        r_found <= n_found;
        r_port  <= n_port;
        r_nh    <= n_nh;
        r_key   <= n_key;
        r_match <= n_match;
        r_mac   <= n_mac;
        r_idx   <= n_idx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    `LPMF_ASSERT(a_count_bound, r_count <= ACW'(ARP_ENTRY_COUNT))
    `LPMF_ASSERT(a_depth_bound, (r_state == S_WALK) |-> (r_depth <= 6'd32))
    `LPMF_ASSERT_NEVER(a_out_in_clear, (r_state == S_CLEAR) && r_ovalid)
    `LPMF_ASSERT(a_learn_grows, arp_we |=> (r_count == $past(r_count) + ACW'(1)))
endmodule
`default_nettype wire

>>> src/ipv4_lpm_trie_arp_forwarder.sv
// Channel  Dir  Handshake                         Payload
// in       in   i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata (command .. ttl_in)
// out      out  o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata (status .. out_ttl)
//
// From accept to result: node write and ttl expiry go straight to the result; ARP
// learn scans the cached entries (one cache read per cycle); lookup does one trie
// read per level (up to 33) through the single trie read port, plus a cache scan
// when a route is found.
// After reset the trie is zeroed one node per cycle; no item is taken meanwhile.
// A two-entry queue keeps taking items while results stall, until it is full.
`default_nettype none
module ipv4_lpm_trie_arp_forwarder #(
    parameter int TRIE_NODE_COUNT = lpmfwd_pkg::TrieNodeCountDef,
    parameter int ARP_ENTRY_COUNT = lpmfwd_pkg::ArpEntryCountDef
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // command, node_index, child_zero, child_one, node_has_route, node_port,
    // node next-hop, ip_address, mac_address, ttl_in, zero pad
    input  wire logic [lpmfwd_pkg::InWidth-1:0]  i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // status, out_port, out next-hop, out_mac, out_ttl, zero pad
    output logic      [lpmfwd_pkg::OutWidth-1:0] o_m_axis_tdata
);
    import lpmfwd_pkg::*;

    logic q_valid, q_pop, clearing;
    t_cmd q_data;

    lpmfwd_front #(.TRIE_NODE_COUNT(TRIE_NODE_COUNT)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_clearing      (clearing),
        .o_q_valid       (q_valid),
        .o_q_data        (q_data),
        .i_q_pop         (q_pop)
    );

    lpmfwd_back #(
        .TRIE_NODE_COUNT (TRIE_NODE_COUNT),
        .ARP_ENTRY_COUNT (ARP_ENTRY_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );
endmodule
`default_nettype wire

>>> bench/tb_ipv4_lpm_trie_arp_forwarder.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_ipv4_lpm_trie_arp_forwarder;
    import lpmfwd_pkg::*;

    localparam int NODES = 4096;
    localparam int ARP_SLOTS = 16;
    localparam logic [1:0] K_LOOKUP_ALT = 2'd3;   // bit 1 set: also a lookup

    typedef struct {
        logic [1:0]  cmd;
        logic [11:0] idx;
        logic [11:0] c0;
        logic [11:0] c1;
        logic        rt;
        logic [3:0]  port;
        logic [31:0] nh;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [7:0]  ttl;
    } t_pkt;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [InWidth-1:0]  i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OutWidth-1:0] o_m_axis_tdata;

    ipv4_lpm_trie_arp_forwarder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // shadow trie and arp cache
    logic [11:0] trie_c0 [NODES];
    logic [11:0] trie_c1 [NODES];
    logic        trie_rt [NODES];
    logic [3:0]  trie_port [NODES];
    logic [31:0] trie_nh [NODES];
    logic [31:0] arp_ip [ARP_SLOTS];
    logic [47:0] arp_mac [ARP_SLOTS];
    int          arp_used;

    t_result     pending_results[$];
    logic [31:0] hop_pool [24];
    int          mismatches;
    int          burst_left;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int arp_lookup(input logic [31:0] ip);
        for (int i = 0; i < arp_used; i++)
            if (arp_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic t_result forward_predict(input t_pkt p);
        t_result r;
        logic [7:0]  ttl_dec;
        logic [11:0] cur;
        logic [11:0] nxt;
        logic        found;
        int          slot;
        r = '0;
        if (p.cmd == K_WRITE) begin
            trie_c0[p.idx] = p.c0;
            trie_c1[p.idx] = p.c1;
            trie_rt[p.idx] = p.rt;
            trie_port[p.idx] = p.port;
            trie_nh[p.idx] = p.nh;
            r.status = ST_NODE_WRITTEN;
        end else if (p.cmd == K_LEARN) begin
            if (arp_lookup(p.ip) >= 0) begin
                r.status = ST_KNOWN;
            end else if (arp_used >= ARP_SLOTS) begin
                r.status = ST_ARP_FULL;
            end else begin
                arp_ip[arp_used] = p.ip;
                arp_mac[arp_used] = p.mac;
                arp_used++;
                r.status = ST_LEARNED;
            end
        end else begin
            ttl_dec = (p.ttl > 0) ? p.ttl - 8'd1 : 8'd0;
            r.ttl = ttl_dec;
            if (ttl_dec == 0) begin
                r.status = ST_TTL_EXPIRED;
                return r;
            end
            cur = '0;
            found = 1'b0;
            // root's own route is never taken: only nodes reached via a link
            for (int d = 0; d <= TopBit; d++) begin
                nxt = p.ip[TopBit - d] ? trie_c1[cur] : trie_c0[cur];
                if (nxt == 0) break;
                cur = nxt;
                if (trie_rt[cur]) begin
                    found = 1'b1;
                    r.port = trie_port[cur];
                    r.hop_addr = trie_nh[cur];
                end
            end
            if (!found) begin
                r.status = ST_NO_ROUTE;
                r.port = '0;
                r.hop_addr = '0;
            end else begin
                slot = arp_lookup(r.hop_addr);
                if (slot >= 0) begin
                    r.status = ST_FORWARD;
                    r.mac = arp_mac[slot];
                end else begin
                    r.status = ST_ARP_NEEDED;
                end
            end
        end
        return r;
    endfunction

    task automatic send_item(input t_pkt p);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {5'd0, p.ttl, p.mac, p.ip, p.nh, p.port, p.rt,
                           p.c1, p.c0, p.idx, p.cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(forward_predict(p));
        // sender bursts: short gaps between random-length runs
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic t_pkt blank_pkt(input logic [1:0] cmd);
        t_pkt p;
        p.cmd = cmd; p.idx = 0; p.c0 = 0; p.c1 = 0; p.rt = 0; p.port = 0;
        p.nh = 0; p.ip = 0; p.mac = 0; p.ttl = 0;
        return p;
    endfunction

    task automatic test_directed();
        t_pkt p;
        // ttl expiry at 0 and 1, empty trie at 255
        p = blank_pkt(K_LOOKUP); p.ttl = 8'd0; p.ip = '1; send_item(p);
        p.ttl = 8'd1; send_item(p);
        p.ttl = 8'd255; send_item(p);
        // root with its own route, child on bit 1 to node 1
        p = blank_pkt(K_WRITE); p.rt = 1; p.port = 4'd9; p.nh = 32'h0a000001;
        p.c1 = 12'd1; send_item(p);
        p = blank_pkt(K_WRITE); p.idx = 12'd1; p.rt = 1; p.port = 4'hf;
        p.nh = 32'hffff_fffe; send_item(p);
        p = blank_pkt(K_LOOKUP); p.ip = 32'h8000_0000; p.ttl = 8'd2; send_item(p);
        p.ip = 32'h0; send_item(p);               // only the root route: no route
        p = blank_pkt(K_LEARN); p.ip = 32'hffff_fffe; p.mac = '1; send_item(p);
        p.mac = 48'h1234; send_item(p);           // known ip keeps old mac
        p = blank_pkt(K_LOOKUP_ALT); p.ip = 32'hffff_ffff; p.ttl = 8'd64;
        send_item(p);
        p = blank_pkt(K_LOOKUP); p.ip = 32'hc000_0000; p.ttl = 8'd3; send_item(p);
        // node 1 links to itself on bit 1: full 32-level walk
        p = blank_pkt(K_WRITE); p.idx = 12'd1; p.c1 = 12'd1; p.c0 = 12'd2;
        p.rt = 1; p.port = 4'd3; p.nh = 32'h0a000001; send_item(p);
        p = blank_pkt(K_LOOKUP); p.ip = 32'hffff_ffff; p.ttl = 8'd200; send_item(p);
        p = blank_pkt(K_WRITE); p.idx = 12'hfff; p.c0 = 12'hfff; p.c1 = 12'hfff;
        p.rt = 1; p.port = 4'hf; p.nh = '1; send_item(p);
        p = blank_pkt(K_LEARN); p.ip = 32'h0; p.mac = 48'h0; send_item(p);
        wait_drained();
    endtask

    function automatic t_pkt random_pkt();
        t_pkt p;
        int   sel;
        sel = $urandom_range(0, 99);
        p = blank_pkt(K_LOOKUP);
        p.ip = $urandom;
        p.mac = {16'($urandom), 32'($urandom)};
        p.nh = $urandom;
        p.port = 4'($urandom);
        p.c0 = 12'($urandom);
        p.c1 = 12'($urandom);
        p.rt = 1'($urandom);
        p.ttl = 8'($urandom);
        if (sel < 30) begin
            // small connected trie: cycles and chains walk deep
            p.cmd = K_WRITE;
            p.idx = 12'($urandom_range(0, 63));
            p.c0 = ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(1, 63));
            p.c1 = ($urandom_range(0, 4) == 0) ? 12'd0 : 12'($urandom_range(1, 63));
            if ($urandom_range(0, 9) != 0) p.nh = hop_pool[$urandom_range(0, 23)];
        end else if (sel < 34) begin
            p.cmd = K_WRITE;
            p.idx = 12'($urandom_range(64, 4095));
        end else if (sel < 48) begin
            p.cmd = K_LEARN;
            if ($urandom_range(0, 4) != 0) p.ip = hop_pool[$urandom_range(0, 23)];
        end else begin
            p.cmd = ($urandom_range(0, 9) == 0) ? K_LOOKUP_ALT : K_LOOKUP;
            if ($urandom_range(0, 9) == 0) p.ttl = 8'($urandom_range(0, 1));
        end
        return p;
    endfunction

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_pkt());
            if (n == count / 2) wait_drained();
        end
    endtask

    function automatic void flag_mismatch(input string what, input t_result want,
                                          input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch %s: expected st=%0d port=%0d nh=%h mac=%h ttl=%0d,",
                      " got st=%0d port=%0d nh=%h mac=%h ttl=%0d"},
                     what, want.status, want.port, want.hop_addr, want.mac, want.ttl,
                     got.status, got.port, got.hop_addr, got.mac, got.ttl);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[94:0]);
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected item", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) flag_mismatch("status", want, got);
                else if (got.port !== want.port) flag_mismatch("port", want, got);
                else if (got.hop_addr !== want.hop_addr) flag_mismatch("hop", want, got);
                else if (got.mac !== want.mac) flag_mismatch("mac", want, got);
                else if (got.ttl !== want.ttl) flag_mismatch("ttl", want, got);
            end
        end
    end

    // receiver: alternates free-running spells with stall-heavy spells
    initial begin
        int spell;
        bit choppy;
        i_m_axis_tready = 1'b0;
        forever begin
            choppy = $urandom_range(0, 1);
            spell = $urandom_range(20, 300);
            repeat (spell) begin
                @(negedge i_clk);
                i_m_axis_tready <= choppy ? ($urandom_range(0, 3) == 0) : 1'b1;
            end
        end
    end

    initial begin
        #10ms;
        $display("tb_ipv4_lpm_trie_arp_forwarder: done, errors");
        $finish;
    end

    initial begin
        mismatches = 0;
        burst_left = 0;
        arp_used = 0;
        for (int i = 0; i < NODES; i++) begin
            trie_c0[i] = '0; trie_c1[i] = '0; trie_rt[i] = 1'b0;
            trie_port[i] = '0; trie_nh[i] = '0;
        end
        for (int i = 0; i < 24; i++) hop_pool[i] = $urandom;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(500);
        wait_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_ipv4_lpm_trie_arp_forwarder: done, clean");
        else
            $display("tb_ipv4_lpm_trie_arp_forwarder: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
